FILE: src/assert_macros.svh
// assertion helpers, clocked on clk_i and held off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define FFBA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define FFBA_NEVER(label, cond, msg) \
  `FFBA_ASSERT(label, !(cond), msg)

`endif

FILE: src/ffba_pkg.sv
package ffba_pkg;

  localparam int MAX_BYTES  = 128;
  localparam int MAX_BLOCKS = 128;
  localparam int ID_BITS    = 16;

  localparam int SIZE_W = $clog2(MAX_BYTES + 1);
  localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
  localparam int WIDE_W = ((SIZE_W > 8) ? SIZE_W : 8) + 2;
  localparam logic [ID_BITS-1:0] ID_LIMIT = {ID_BITS{1'b1}};

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_ERASE  = 2'd1,
    OP_DEFRAG = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_ALLOCATED = 2'd0,
    ST_FAILED    = 2'd1,
    ST_ILLEGAL   = 2'd2,
    ST_UNUSED    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_RESULT
  } state_e;

  typedef struct packed {
    logic [SIZE_W-1:0]  start;
    logic [SIZE_W-1:0]  size;
    logic [ID_BITS-1:0] id;
  } entry_t;

  typedef struct packed {
    logic   shift;
    entry_t feed;
  } chain_ctl_t;

endpackage

FILE: src/ffba_in_if.sv
interface ffba_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [7:0]  amount;
  logic [15:0] block_id;
  modport source (output valid, op, amount, block_id, input ready);
  modport sink (input valid, op, amount, block_id, output ready);
endinterface

FILE: src/ffba_out_if.sv
interface ffba_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] new_id;
  modport source (output valid, status, new_id, input ready);
  modport sink (input valid, status, new_id, output ready);
endinterface

FILE: src/ffba_cfg_if.sv
interface ffba_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] memory_size;
  modport source (output valid, memory_size, input ready);
  modport sink (input valid, memory_size, output ready);
endinterface

FILE: src/ffba_cell.sv
module ffba_cell (
  input  logic              clk_i,
  input  logic              shift_i,
  input  ffba_pkg::entry_t  d_i,
  output ffba_pkg::entry_t  q_o
);

  ffba_pkg::entry_t entry_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      entry_q <= d_i;
    end
  end

  assign q_o = entry_q;

endmodule

FILE: src/ffba_ctrl.sv
`include "assert_macros.svh"

module ffba_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [1:0]             op_i,
  input  logic [7:0]             amount_i,
  input  logic [15:0]            block_id_i,
  input  logic [7:0]             mem_size_i,
  input  ffba_pkg::entry_t       head_i,
  input  ffba_pkg::entry_t       next_i,
  output ffba_pkg::chain_ctl_t   ctl_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [1:0]             status_o,
  output logic [15:0]            new_id_o
);

  localparam int W = ffba_pkg::WIDE_W;

  ffba_pkg::state_e state_q, state_d;
  ffba_pkg::op_e    op_q, op_d;
  logic [7:0]                   amount_q, amount_d;
  logic [15:0]                  target_q, target_d;
  logic [ffba_pkg::CNT_W-1:0]   step_q, step_d;
  logic [ffba_pkg::CNT_W-1:0]   count_q, count_d;
  logic [ffba_pkg::ID_BITS-1:0] next_id_q, next_id_d;
  logic [ffba_pkg::SIZE_W:0]    cursor_q, cursor_d;
  logic [ffba_pkg::SIZE_W:0]    pos_q, pos_d;
  logic                         found_q, found_d;
  ffba_pkg::entry_t             carry_q, carry_d;
  logic                         ovalid_q, ovalid_d;
  logic [1:0]                   status_q, status_d;
  logic [15:0]                  new_id_q, new_id_d;

  logic          live, ok, fit, tail_fit, last;
  logic [W-1:0]  w_start, w_cur, w_amt, w_lim;
  ffba_pkg::entry_t fresh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ffba_pkg::S_IDLE;
      count_q   <= '0;
      next_id_q <= ffba_pkg::ID_BITS'(1);
      ovalid_q  <= 1'b0;
      step_q    <= '0;
      found_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      next_id_q <= next_id_d;
      ovalid_q  <= ovalid_d;
      step_q    <= step_d;
      found_q   <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    amount_q <= amount_d;
    target_q <= target_d;
    cursor_q <= cursor_d;
    pos_q    <= pos_d;
    carry_q  <= carry_d;
    status_q <= status_d;
    new_id_q <= new_id_d;
  end

  assign w_start = W'(head_i.start);
  assign w_cur   = W'(cursor_q);
  assign w_amt   = W'(amount_q);
  assign w_lim   = (mem_size_i > 8'(ffba_pkg::MAX_BYTES)) ? W'(ffba_pkg::MAX_BYTES)
                                                         : W'(mem_size_i);
  assign live     = step_q < count_q;
  assign last     = step_q == ffba_pkg::CNT_W'(ffba_pkg::MAX_BLOCKS - 1);
  assign ok       = (amount_q != 8'd0) && (count_q < ffba_pkg::CNT_W'(ffba_pkg::MAX_BLOCKS));
  assign fit      = (w_start >= w_cur) && ((w_start - w_cur) >= w_amt);
  assign tail_fit = (w_lim >= w_cur) && ((w_lim - w_cur) >= w_amt);

  always_comb begin
    fresh.start = ffba_pkg::SIZE_W'(cursor_q);
    fresh.size  = ffba_pkg::SIZE_W'(amount_q);
    fresh.id    = next_id_q;
  end

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    amount_d  = amount_q;
    target_d  = target_q;
    step_d    = step_q;
    count_d   = count_q;
    next_id_d = next_id_q;
    cursor_d  = cursor_q;
    pos_d     = pos_q;
    found_d   = found_q;
    carry_d   = carry_q;
    ovalid_d  = ovalid_q;
    status_d  = status_q;
    new_id_d  = new_id_q;
    ctl_o.shift = 1'b0;
    ctl_o.feed  = head_i;
    in_ready_o  = 1'b0;

    if (ovalid_q && out_ready_i) begin
      ovalid_d = 1'b0;
    end

    case (state_q)
      ffba_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d     = ffba_pkg::op_e'(op_i);
          amount_d = amount_i;
          target_d = block_id_i;
          step_d   = '0;
          cursor_d = '0;
          pos_d    = '0;
          found_d  = 1'b0;
          state_d  = ffba_pkg::S_WALK;
        end
      end
      ffba_pkg::S_WALK: begin
        ctl_o.shift = 1'b1;
        case (op_q)
          ffba_pkg::OP_ALLOC: begin
            if (found_q) begin
              ctl_o.feed = carry_q;
              carry_d    = head_i;
            end else if (ok && live) begin
              if (fit) begin
                ctl_o.feed = fresh;
                carry_d    = head_i;
                found_d    = 1'b1;
              end else begin
                cursor_d = (ffba_pkg::SIZE_W + 1)'(head_i.start)
                         + (ffba_pkg::SIZE_W + 1)'(head_i.size);
              end
            end else if (ok && step_q == count_q && tail_fit) begin
              ctl_o.feed = fresh;
              carry_d    = head_i;
              found_d    = 1'b1;
            end
          end
          ffba_pkg::OP_ERASE: begin
            if (found_q) begin
              ctl_o.feed = next_i;
            end else if (live && (32'(head_i.id) == 32'(target_q))) begin
              ctl_o.feed = next_i;
              found_d    = 1'b1;
            end
          end
          ffba_pkg::OP_DEFRAG: begin
            if (live) begin
              ctl_o.feed.start = ffba_pkg::SIZE_W'(pos_q);
              pos_d = pos_q + (ffba_pkg::SIZE_W + 1)'(head_i.size);
            end
          end
          default: begin
          end
        endcase
        step_d = step_q + 1'b1;
        if (last) begin
          state_d = ffba_pkg::S_RESULT;
        end
      end
      ffba_pkg::S_RESULT: begin
        if (!ovalid_q || out_ready_i) begin
          state_d = ffba_pkg::S_IDLE;
          case (op_q)
            ffba_pkg::OP_ALLOC: begin
              ovalid_d = 1'b1;
              if (found_q) begin
                status_d = ffba_pkg::ST_ALLOCATED;
                new_id_d = 16'(next_id_q);
                count_d  = count_q + 1'b1;
                if (next_id_q != ffba_pkg::ID_LIMIT) begin
                  next_id_d = next_id_q + 1'b1;
                end
              end else begin
                status_d = ffba_pkg::ST_FAILED;
                new_id_d = '0;
              end
            end
            ffba_pkg::OP_ERASE: begin
              if (found_q) begin
                count_d = count_q - 1'b1;
              end else begin
                ovalid_d = 1'b1;
                status_d = ffba_pkg::ST_ILLEGAL;
                new_id_d = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_d = ffba_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid_o = ovalid_q;
  assign status_o    = status_q;
  assign new_id_o    = new_id_q;

  `FFBA_ASSERT(a_count_bound, count_q <= ffba_pkg::CNT_W'(ffba_pkg::MAX_BLOCKS), "live count overflow")
  `FFBA_ASSERT(a_walk_starts, (in_valid_i && in_ready_o) |=> (state_q == ffba_pkg::S_WALK && step_q == '0), "walk did not start at entry zero")
  `FFBA_NEVER(a_no_accept_busy, in_ready_o && state_q != ffba_pkg::S_IDLE, "item taken while busy")

endmodule

FILE: src/first_fit_block_allocator_core.sv
// an accepted item walks the cell ring in S_WALK, then S_RESULT registers its result beat once
// no earlier result is left pending; defrag and a successful erase give no result beat at all
// every item rotates the whole cell ring once, one entry per cycle, before the next is taken
// reset: live count 0, next id 1, memory_size 128; cell contents are not cleared
module first_fit_block_allocator_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  ffba_in_if.sink        in_s,
  ffba_out_if.source     out_m,
  ffba_cfg_if.sink       cfg_s
);

  localparam int N = ffba_pkg::MAX_BLOCKS;

  logic [7:0]           mem_size_q;
  ffba_pkg::entry_t     q [N];
  ffba_pkg::entry_t     next_entry;
  ffba_pkg::chain_ctl_t ctl;

  assign cfg_s.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_size_q <= 8'(ffba_pkg::MAX_BYTES);
    end else if (cfg_s.valid) begin
      mem_size_q <= cfg_s.memory_size;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    ffba_pkg::entry_t d;
    if (i == N - 1) begin : g_tail
      assign d = ctl.feed;
    end else begin : g_body
      assign d = q[i+1];
    end
    ffba_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (ctl.shift),
      .d_i     (d),
      .q_o     (q[i])
    );
  end

  if (N > 1) begin : g_next
    assign next_entry = q[1];
  end else begin : g_next_one
    assign next_entry = q[0];
  end

  ffba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_s.valid),
    .in_ready_o  (in_s.ready),
    .op_i        (in_s.op),
    .amount_i    (in_s.amount),
    .block_id_i  (in_s.block_id),
    .mem_size_i  (mem_size_q),
    .head_i      (q[0]),
    .next_i      (next_entry),
    .ctl_o       (ctl),
    .out_valid_o (out_m.valid),
    .out_ready_i (out_m.ready),
    .status_o    (out_m.status),
    .new_id_o    (out_m.new_id)
  );

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;

  typedef struct {
    logic [1:0]  status;
    logic [15:0] new_id;
  } alloc_result_t;

  class alloc_scoreboard;
    int            starts[$];
    int            sizes[$];
    int            ids[$];
    int            next_id = 1;
    int            mem_size = 128;
    alloc_result_t pending[$];
    int            errors = 0;

    function void fail(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    function void note_item(logic [1:0] op, logic [7:0] amount, logic [15:0] bid);
      int            cursor;
      int            slot;
      int            lim;
      bit            found;
      alloc_result_t r;
      cursor = 0;
      slot = 0;
      found = 0;
      case (op)
        ffba_pkg::OP_ALLOC: begin
          if (amount != 0 && ids.size() < ffba_pkg::MAX_BLOCKS) begin
            for (int i = 0; i < ids.size(); i++) begin
              if (starts[i] >= cursor && starts[i] - cursor >= amount) begin
                slot = i;
                found = 1;
                break;
              end
              cursor = starts[i] + sizes[i];
            end
            if (!found) begin
              lim = (mem_size > ffba_pkg::MAX_BYTES) ? ffba_pkg::MAX_BYTES : mem_size;
              if (lim >= cursor && lim - cursor >= amount) begin
                slot = ids.size();
                found = 1;
              end
            end
          end
          if (!found) begin
            r.status = ffba_pkg::ST_FAILED;
            r.new_id = '0;
          end else begin
            starts.insert(slot, cursor);
            sizes.insert(slot, amount);
            ids.insert(slot, next_id);
            r.status = ffba_pkg::ST_ALLOCATED;
            r.new_id = 16'(next_id);
            if (next_id < int'(ffba_pkg::ID_LIMIT)) next_id++;
          end
          pending.insert(pending.size(), r);
        end
        ffba_pkg::OP_ERASE: begin
          for (int i = 0; i < ids.size(); i++) begin
            if (ids[i] == int'(bid)) begin
              starts.delete(i);
              sizes.delete(i);
              ids.delete(i);
              found = 1;
              break;
            end
          end
          if (!found) begin
            r.status = ffba_pkg::ST_ILLEGAL;
            r.new_id = '0;
            pending.insert(pending.size(), r);
          end
        end
        ffba_pkg::OP_DEFRAG: begin
          for (int i = 0; i < ids.size(); i++) begin
            starts[i] = cursor;
            cursor += sizes[i];
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [1:0] status, logic [15:0] new_id);
      alloc_result_t r;
      if (pending.size() == 0) begin
        fail($sformatf("unexpected result status=%0d new_id=%0d", status, new_id));
        return;
      end
      r = pending.pop_front();
      if (status !== r.status || new_id !== r.new_id)
        fail($sformatf("mismatch: expected status=%0d new_id=%0d, got status=%0d new_id=%0d",
                       r.status, r.new_id, status, new_id));
    endfunction
  endclass

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = ffba_pkg::MAX_BLOCKS + 10;

  logic clk_i = 1'b0;
  logic rst_ni;

  ffba_in_if  in_if ();
  ffba_out_if out_if ();
  ffba_cfg_if cfg_if ();

  first_fit_block_allocator_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_s   (in_if),
    .out_m  (out_if),
    .cfg_s  (cfg_if)
  );

  alloc_scoreboard sb = new();
  int send_idle;
  int recv_idle;
  int stall_cycles;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // result check and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) sb.check_result(out_if.status, out_if.new_id);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("** first_fit_block_allocator_core: FAILED **");
        $finish;
      end
    end
  end

  task automatic send(logic [1:0] op, logic [7:0] amount, logic [15:0] bid);
    while ($urandom_range(99) < send_idle) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid    <= 1'b1;
    in_if.op       <= op;
    in_if.amount   <= amount;
    in_if.block_id <= bid;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_item(op, amount, bid);
  endtask

  task automatic write_mem_size(logic [7:0] value);
    in_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_if.valid       <= 1'b1;
    cfg_if.memory_size <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    sb.mem_size = value;
  endtask

  initial begin
    int          mem_plan[9];
    int          pick;
    logic [7:0]  amt;
    logic [15:0] bid;
    mem_plan = '{128, 0, 255, 1, 128, 64, 17, 200, 128};
    stall_cycles = 0;
    send_idle = 32;
    recv_idle = 64;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.op = ffba_pkg::OP_ALLOC;
    in_if.amount = '0;
    in_if.block_id = '0;
    cfg_if.valid = 1'b0;
    cfg_if.memory_size = 8'd128;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed
    send(ffba_pkg::OP_ALLOC, 8'd0, 16'd0);
    send(ffba_pkg::OP_ALLOC, 8'd128, 16'd0);
    send(ffba_pkg::OP_ALLOC, 8'd1, 16'd0);
    send(ffba_pkg::OP_ERASE, 8'd0, 16'd1);
    send(ffba_pkg::OP_ERASE, 8'd0, 16'd1);
    send(ffba_pkg::OP_ALLOC, 8'd255, 16'd0);
    send(ffba_pkg::OP_NONE, 8'hff, 16'hffff);
    send(ffba_pkg::OP_DEFRAG, 8'd0, 16'd0);
    send(ffba_pkg::OP_ALLOC, 8'd10, 16'd0);
    send(ffba_pkg::OP_ALLOC, 8'd20, 16'd0);
    send(ffba_pkg::OP_ALLOC, 8'd30, 16'd0);
    send(ffba_pkg::OP_ERASE, 8'd0, 16'd3);
    send(ffba_pkg::OP_ALLOC, 8'd25, 16'd0);
    send(ffba_pkg::OP_DEFRAG, 8'd0, 16'd0);
    send(ffba_pkg::OP_ALLOC, 8'd68, 16'd0);
    send(ffba_pkg::OP_ALLOC, 8'd63, 16'd0);
    send(ffba_pkg::OP_ERASE, 8'd0, 16'hffff);
    send(ffba_pkg::OP_ERASE, 8'd0, 16'h0000);
    write_mem_size(8'd40);
    send(ffba_pkg::OP_ALLOC, 8'd1, 16'd0);
    send(ffba_pkg::OP_ERASE, 8'd0, 16'd2);
    send(ffba_pkg::OP_ALLOC, 8'd5, 16'd0);
    write_mem_size(8'd0);
    send(ffba_pkg::OP_ALLOC, 8'd3, 16'd0);
    send(ffba_pkg::OP_ALLOC, 8'd3, 16'd0);

    // random phases
    for (int ph = 0; ph < 9; ph++) begin
      if (ph == 3) begin
        send_idle = 64;
        recv_idle = 32;
      end else if (ph == 6) begin
        send_idle = 0;
        recv_idle = 0;
      end
      if (ph == 4) begin
        while (sb.ids.size() > 0) send(ffba_pkg::OP_ERASE, 8'd0, 16'(sb.ids[0]));
      end
      write_mem_size(8'(mem_plan[ph]));
      for (int n = 0; n < ((ph == 4) ? 132 : 100); n++) begin
        pick = $urandom_range(99);
        if (ph == 4) begin
          send(ffba_pkg::OP_ALLOC, 8'd1, 16'd0);
        end else if (pick < 50) begin
          amt = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(24, 1));
          send(ffba_pkg::OP_ALLOC, amt, 16'($urandom_range(65535)));
        end else if (pick < 82) begin
          if (sb.ids.size() > 0 && $urandom_range(4) != 0)
            bid = 16'(sb.ids[$urandom_range(sb.ids.size() - 1)]);
          else
            bid = 16'($urandom_range(65535));
          send(ffba_pkg::OP_ERASE, 8'($urandom_range(255)), bid);
        end else if (pick < 95) begin
          send(ffba_pkg::OP_DEFRAG, 8'($urandom_range(255)), 16'($urandom_range(65535)));
        end else begin
          send(ffba_pkg::OP_NONE, 8'($urandom_range(255)), 16'($urandom_range(65535)));
        end
      end
    end

    in_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("** first_fit_block_allocator_core: PASSED **");
    end else begin
      $display("** first_fit_block_allocator_core: FAILED **");
    end
    $finish;
  end

endmodule
